// File: rtl/rlht_pkg.sv
// Package for the reentrant lock hold table: sizes, codes, payload and cell types.
// Used by every module under rtl/; depends on nothing else.
package rlht_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 32;
  localparam int MODE_W      = 2;
  localparam int ENTRIES_W   = 4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ACQ = 2'd0,
    CMD_TRY = 2'd1,
    CMD_REL = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WAIT     = 2'd1,
    ST_ERR      = 2'd2,
    ST_DEADLOCK = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FWD_NONE = 2'd0,
    FWD_ACQ  = 2'd1,
    FWD_TRY  = 2'd2,
    FWD_REL  = 2'd3
  } fwd_e;

  // Shared lock outcome codes; anything else counts as an error.
  localparam logic [1:0] OC_GRANT = 2'd0;
  localparam logic [1:0] OC_WAIT  = 2'd1;

  localparam logic [MODE_W-1:0] MODE_NULL = '0;
  localparam logic [ID_W-1:0]   ID_NULL   = '0;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_CLEAR = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INC    = 3'd2,
    OP_DEC    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_SHIFT  = 3'd5
  } cell_op_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ID_W-1:0]   lock_id;
    logic [MODE_W-1:0] lock_mode;
    logic [1:0]        shared_outcome;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    fwd_e                 forwarded_op;
    logic                 mode_warning;
    logic [ID_W-1:0]      released_id;
    logic [ENTRIES_W-1:0] entries_used;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [MODE_W-1:0]      mode;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e          op;
    logic [ID_W-1:0]   id;
    logic [MODE_W-1:0] mode;
  } cell_ctl_t;

endpackage

// File: rtl/rlht_cell.sv
// One table slot: id, mode and reentry count, with compare and neighbor shift.
// Depends on rlht_pkg.
module rlht_cell (
  input  logic                           clk,
  input  logic [rlht_pkg::IDX_W-1:0]     cell_idx,
  input  logic [rlht_pkg::USED_W-1:0]    used,
  input  rlht_pkg::cell_ctl_t            ctl,
  input  rlht_pkg::entry_t               nbr_in,
  input  logic                           shift_in,
  output logic                           shift_out,
  output logic                           hit,
  output rlht_pkg::entry_t               entry
);

  rlht_pkg::entry_t entry_r;
  rlht_pkg::entry_t entry_nxt;
  logic             in_use;
  logic             at_end;

  always_comb begin
    in_use    = rlht_pkg::USED_W'(cell_idx) < used;
    at_end    = rlht_pkg::USED_W'(cell_idx) == used;
    hit       = in_use && (entry_r.id == ctl.id);
    // everything from the removed slot upward pulls in its right neighbor
    shift_out = shift_in | hit;
    entry_nxt = entry_r;
    case (ctl.op)
      rlht_pkg::OP_APPEND: begin
        if (at_end) begin
          entry_nxt.id    = ctl.id;
          entry_nxt.mode  = ctl.mode;
          entry_nxt.count = rlht_pkg::COUNT_WIDTH'(1);
        end
      end
      rlht_pkg::OP_INC: begin
        if (hit && entry_r.count != rlht_pkg::COUNT_MAX)
          entry_nxt.count = entry_r.count + rlht_pkg::COUNT_WIDTH'(1);
      end
      rlht_pkg::OP_DEC: begin
        if (hit) entry_nxt.count = entry_r.count - rlht_pkg::COUNT_WIDTH'(1);
      end
      rlht_pkg::OP_REMOVE: begin
        if (shift_out) entry_nxt = nbr_in;
      end
      rlht_pkg::OP_SHIFT: begin
        entry_nxt = nbr_in;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: rtl/reentrant_lock_hold_table.sv
// Top level of the reentrant lock hold table: controller, output register, cell chain.
// Depends on rlht_pkg and rlht_cell.
//
// The table is a chain of TABLE_DEPTH cells kept compacted from cell 0 upward; an
// acquire/try-acquire/release transaction is latched at the accepting edge and evaluated
// in the next cycle, where every cell compares its id against the request in parallel and
// the matched cell bumps, drops, or (with every cell above it) shifts down one slot. The
// result is registered at the end of evaluation and the controller then returns to idle,
// where the next transaction can be accepted. Clear evaluates first and then releases one
// held lock per cycle while the output does not stall: the chain shifts toward cell 0 on
// each release and cell 0's id goes out as one release transaction, with last set on the
// final one (an empty table gives a single result from the evaluation step). A stall on
// the output side holds the controller until the result register frees up. in_stall is
// high whenever a transaction is being evaluated or drained. Table contents are not
// cleared by reset; only the entry count is, and slots above the count are never
// looked at.
module reentrant_lock_hold_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rlht_pkg::out_item_t out_data
);

  localparam int D = rlht_pkg::TABLE_DEPTH;

  rlht_pkg::state_e                state_r, state_nxt;
  logic [rlht_pkg::USED_W-1:0]     used_r, used_nxt;
  logic [rlht_pkg::USED_W-1:0]     rem_r, rem_nxt;
  rlht_pkg::in_item_t              item_r;
  logic                            out_valid_r, out_valid_nxt;
  rlht_pkg::out_item_t             out_data_r, res;
  logic                            emit;
  logic                            slot_free;

  rlht_pkg::cell_ctl_t             ctl;
  rlht_pkg::entry_t                ents [D];
  logic [D-1:0]                    hits;
  logic [D-1:0]                    shifts;

  logic                            any_hit;
  logic [rlht_pkg::MODE_W-1:0]     hit_mode;
  logic [rlht_pkg::COUNT_WIDTH-1:0] hit_count;
  rlht_pkg::status_e               oc_status;
  logic                            id_null, tbl_full, tbl_empty;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic             sh_in;
    rlht_pkg::entry_t nbr;
    if (i == 0) begin : g_first
      assign sh_in = 1'b0;
    end else begin : g_rest
      assign sh_in = shifts[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign nbr = ents[i];
    end else begin : g_body
      assign nbr = ents[i+1];
    end
    rlht_cell u_cell (
      .clk       (clk),
      .cell_idx  (rlht_pkg::IDX_W'(i)),
      .used      (used_r),
      .ctl       (ctl),
      .nbr_in    (nbr),
      .shift_in  (sh_in),
      .shift_out (shifts[i]),
      .hit       (hits[i]),
      .entry     (ents[i])
    );
  end

  // Ids in use are unique, so at most one cell hits; OR-merge its fields.
  always_comb begin
    hit_mode  = '0;
    hit_count = '0;
    for (int i = 0; i < D; i++) begin
      if (hits[i]) begin
        hit_mode  = hit_mode | ents[i].mode;
        hit_count = hit_count | ents[i].count;
      end
    end
  end

  assign any_hit   = |hits;
  assign id_null   = item_r.lock_id == rlht_pkg::ID_NULL;
  assign tbl_full  = used_r >= rlht_pkg::USED_W'(D);
  assign tbl_empty = used_r == '0;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    if (item_r.shared_outcome == rlht_pkg::OC_GRANT)     oc_status = rlht_pkg::ST_OK;
    else if (item_r.shared_outcome == rlht_pkg::OC_WAIT) oc_status = rlht_pkg::ST_WAIT;
    else                                                 oc_status = rlht_pkg::ST_ERR;
  end

  // ---------------- controller ----------------
  always_comb begin
    state_nxt        = state_r;
    used_nxt         = used_r;
    rem_nxt          = rem_r;
    emit             = 1'b0;
    ctl.op           = rlht_pkg::OP_HOLD;
    ctl.id           = item_r.lock_id;
    ctl.mode         = item_r.lock_mode;
    res.status       = rlht_pkg::ST_OK;
    res.forwarded_op = rlht_pkg::FWD_NONE;
    res.mode_warning = 1'b0;
    res.released_id  = '0;
    res.last         = 1'b1;

    case (state_r)
      rlht_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rlht_pkg::S_EVAL;
      end

      rlht_pkg::S_EVAL: begin
        case (item_r.cmd)
          rlht_pkg::CMD_ACQ, rlht_pkg::CMD_TRY: begin
            emit = slot_free;
            if (id_null || tbl_full) begin
              res.status = rlht_pkg::ST_ERR;
            end else if (any_hit) begin
              if (hit_mode == item_r.lock_mode) begin
                ctl.op = rlht_pkg::OP_INC;
              end else begin
                res.status = rlht_pkg::ST_DEADLOCK;
              end
            end else begin
              res.status       = oc_status;
              res.forwarded_op = (item_r.cmd == rlht_pkg::CMD_ACQ) ?
                                 rlht_pkg::FWD_ACQ : rlht_pkg::FWD_TRY;
              if (oc_status == rlht_pkg::ST_OK) begin
                ctl.op   = rlht_pkg::OP_APPEND;
                used_nxt = used_r + rlht_pkg::USED_W'(1);
              end
            end
          end

          rlht_pkg::CMD_REL: begin
            emit = slot_free;
            if (id_null || tbl_empty) begin
              res.status = rlht_pkg::ST_ERR;
            end else begin
              res.mode_warning = any_hit && (hit_mode != item_r.lock_mode) &&
                                 (item_r.lock_mode != rlht_pkg::MODE_NULL);
              if (any_hit && hit_count > rlht_pkg::COUNT_WIDTH'(1)) begin
                ctl.op = rlht_pkg::OP_DEC;
              end else begin
                res.status       = oc_status;
                res.forwarded_op = rlht_pkg::FWD_REL;
                if (oc_status == rlht_pkg::ST_OK && any_hit) begin
                  ctl.op   = rlht_pkg::OP_REMOVE;
                  used_nxt = used_r - rlht_pkg::USED_W'(1);
                end
              end
            end
          end

          rlht_pkg::CMD_CLR: begin
            if (tbl_empty) begin
              emit = slot_free;
            end else begin
              // drain the chain through cell 0; count drops to zero right away
              rem_nxt   = used_r;
              used_nxt  = '0;
              state_nxt = rlht_pkg::S_CLEAR;
            end
          end

          default: begin
            emit = 1'b0;
          end
        endcase
        if (item_r.cmd != rlht_pkg::CMD_CLR || tbl_empty) begin
          if (!slot_free) begin
            ctl.op   = rlht_pkg::OP_HOLD;
            used_nxt = used_r;
          end else begin
            state_nxt = rlht_pkg::S_IDLE;
          end
        end
      end

      rlht_pkg::S_CLEAR: begin
        res.forwarded_op = rlht_pkg::FWD_REL;
        res.released_id  = ents[0].id;
        res.last         = rem_r == rlht_pkg::USED_W'(1);
        if (slot_free) begin
          emit    = 1'b1;
          ctl.op  = rlht_pkg::OP_SHIFT;
          rem_nxt = rem_r - rlht_pkg::USED_W'(1);
          if (rem_r == rlht_pkg::USED_W'(1)) state_nxt = rlht_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rlht_pkg::S_IDLE;
      end
    endcase

    res.entries_used = rlht_pkg::ENTRIES_W'(used_nxt);
  end

  assign out_valid_nxt = emit ? 1'b1 : (slot_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlht_pkg::S_IDLE;
      used_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rlht_pkg::S_IDLE && in_valid) item_r <= in_data;
    if (emit) out_data_r <= res;
  end

  assign in_stall  = state_r != rlht_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/rlht_checker.sv
// Port-level checker for reentrant_lock_hold_table, bound to the top level.
// Depends on rlht_pkg and the top level's ports.
module rlht_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rlht_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rlht_pkg::out_item_t out_data
);

  // a result held under stall stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after an acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a transaction while busy");

  // only a clear run produces non-final results
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.forwarded_op == rlht_pkg::FWD_REL && out_data.entries_used == '0)
    else $error("non-final result outside a clear run");

  // a released id only shows in a clear release
  a_rid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.released_id != '0 |->
      out_data.forwarded_op == rlht_pkg::FWD_REL && out_data.status == rlht_pkg::ST_OK)
    else $error("released id outside a clear");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entries_used <= rlht_pkg::ENTRIES_W'(rlht_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

endmodule

bind reentrant_lock_hold_table rlht_checker u_rlht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
